/* rtl/dssw_pkg.sv */
// ----------------------------------------------------------------------------
// dssw_pkg: shared types and constants for the square wave generator
// Holds the item and result word layouts, opcode values, controller
// states, controller commands and the fixed constants of the half period.
// ----------------------------------------------------------------------------
package dssw_pkg;

	// Field widths of the result word
	localparam int SP_FIELD_W = 14;
	localparam int HP_W       = 14;

	// Opcode values of an input word
	localparam logic [1:0] OP_DIGIT      = 2'd0;
	localparam logic [1:0] OP_START_STOP = 2'd1;
	localparam logic [1:0] OP_TICK       = 2'd2;

	// Largest legal decimal digit
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// Half period: ceil(HALF_NUM / (value * VALUE_SCALE)),
	// value = setpoint / VALUE_DIVISOR + 50 = (setpoint + VALUE_BIAS) / VALUE_DIVISOR
	localparam int              HALF_W        = 29;
	localparam logic [HALF_W-1:0] HALF_NUM    = 29'd460829493;
	localparam int              VALUE_DIVISOR = 3;
	localparam int              VALUE_BIAS    = 150;
	localparam int              VALUE_OFFSET  = VALUE_BIAS / VALUE_DIVISOR;
	localparam int              VALUE_SCALE   = 1000;
	localparam int              SCALE_W       = 10;
	localparam logic [HP_W-1:0] HP_MAX        = 14'd9217;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] digit;
	} key_word_t;

	typedef struct packed {
		logic                  wave_level;
		logic                  running;
		logic [SP_FIELD_W-1:0] setpoint;
		logic [HP_W-1:0]       half_period_ticks;
	} stat_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEN,
		ST_DIVH,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic apply;     // apply any item but a start and emit its result
		logic div_load;  // load value = setpoint / 3 + offset into the divider
		logic div_step;  // one restoring divide step
		logic den_load;  // load half period numerator over value * scale
		logic finish;    // commit half period, start running, emit result
	} ctrl_cmd_t;

	// Power of ten, evaluated at elaboration
	function automatic longint pow10(input int n);
		longint acc;
		acc = 1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 10;
		end
		return acc;
	endfunction

endpackage

/* rtl/dssw_ctrl.sv */
// ----------------------------------------------------------------------------
// dssw_ctrl: item controller
// Accepts key words, applies all items but a start at once and sequences the
// half period divide of a start item through the datapath.
// ----------------------------------------------------------------------------
module dssw_ctrl #(
	parameter int STEPS = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_valid,
	output logic                  key_stall,
	input  logic [1:0]            opcode,
	input  logic                  active,
	input  logic                  obuf_full,
	output dssw_pkg::ctrl_cmd_t   cmd
);

	localparam int STEP_W = $clog2(STEPS);

	dssw_pkg::ctrl_state_t state_q, state_d;
	logic [STEP_W-1:0]     cnt_q, cnt_d;
	logic                  accept;

	// Hold the state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dssw_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign key_stall = (state_q != dssw_pkg::ST_IDLE) || obuf_full;
	assign accept    = key_valid && !key_stall;

	// Decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			dssw_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == dssw_pkg::OP_START_STOP && !active) begin
						cmd.div_load = 1'b1;
						state_d      = dssw_pkg::ST_DEN;
					end else begin
						cmd.apply = 1'b1;
					end
				end
			end
			dssw_pkg::ST_DEN: begin
				cmd.den_load = 1'b1;
				cnt_d        = STEP_W'(STEPS - 1);
				state_d      = dssw_pkg::ST_DIVH;
			end
			dssw_pkg::ST_DIVH: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = dssw_pkg::ST_FIN;
				end
			end
			dssw_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = dssw_pkg::ST_IDLE;
			end
			default: begin
				state_d = dssw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/dssw_dp.sv */
// ----------------------------------------------------------------------------
// dssw_dp: generator datapath
// Digit store and binary setpoint, tick counter and output level, a
// reciprocal multiply for the value and a one-bit-per-cycle restoring
// divider for the half period.
// ----------------------------------------------------------------------------
module dssw_dp #(
	parameter int DIGIT_COUNT = 4,
	parameter int SP_W        = 14,
	parameter int VAL_W       = 12,
	parameter int DEN_W       = 22,
	parameter int DVD_W       = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dssw_pkg::ctrl_cmd_t   cmd,
	input  dssw_pkg::key_word_t   key_word,
	output logic                  active,
	output dssw_pkg::stat_word_t  result
);

	localparam int                 HP_W  = dssw_pkg::HP_W;
	localparam logic [SP_W+3:0]    POW_N = (SP_W + 4)'(dssw_pkg::pow10(DIGIT_COUNT));
	// ceil(2^(SP_W+1) / 3): exact floor division by three for any SP_W-bit setpoint
	localparam logic [SP_W-1:0]    RECIP_DIV = SP_W'(((longint'(1) << (SP_W + 1))
		+ longint'(dssw_pkg::VALUE_DIVISOR) - 1) / longint'(dssw_pkg::VALUE_DIVISOR));

	// Architectural state
	logic [3:0]      digit_q [DIGIT_COUNT];
	logic [3:0]      digit_d [DIGIT_COUNT];
	logic [SP_W-1:0] sp_q, sp_d;
	logic [HP_W-1:0] hp_q, hp_d;
	logic [HP_W-1:0] tick_q, tick_d;
	logic            level_q, level_d;
	logic            active_q, active_d;

	// Divider registers
	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] dsr_q;
	logic [DEN_W-1:0] rem_q;

	logic [SP_W+3:0]        sp10;
	logic [SP_W-1:0]        sp_shift;
	logic [HP_W-1:0]        tick_inc;
	logic [2*SP_W-1:0]      sp_prod;
	logic [VAL_W-1:0]       value_calc;
	logic [DEN_W:0]         trial;
	logic                   ge;
	logic [DEN_W:0]         trial_sub;
	logic [VAL_W+dssw_pkg::SCALE_W-1:0] den_full;
	logic [HP_W-1:0]        hp_calc;

	// Shift a digit into the setpoint: old * 10 + digit - oldest * 10^N
	assign sp10     = ((SP_W + 4)'(sp_q) << 3) + ((SP_W + 4)'(sp_q) << 1);
	assign sp_shift = SP_W'(sp10 + (SP_W + 4)'(key_word.digit)
		- POW_N * (SP_W + 4)'(digit_q[DIGIT_COUNT-1]));
	assign tick_inc = tick_q + 1'b1;

	// Value from the setpoint: multiply by the reciprocal of three, add the offset
	assign sp_prod    = (2 * SP_W)'(sp_q) * (2 * SP_W)'(RECIP_DIV);
	assign value_calc = VAL_W'(sp_prod >> (SP_W + 1)) + VAL_W'(dssw_pkg::VALUE_OFFSET);

	// Restoring divide step and half period rounding up
	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign ge        = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign den_full  = (VAL_W + dssw_pkg::SCALE_W)'(dvd_q[VAL_W-1:0])
		* (VAL_W + dssw_pkg::SCALE_W)'(dssw_pkg::VALUE_SCALE);
	assign hp_calc   = dvd_q[HP_W-1:0] + HP_W'(rem_q != '0);

	// Next state for the item being applied and for a committed half period
	always_comb begin
		digit_d  = digit_q;
		sp_d     = sp_q;
		hp_d     = hp_q;
		tick_d   = tick_q;
		level_d  = level_q;
		active_d = active_q;
		if (cmd.apply) begin
			case (key_word.opcode)
				dssw_pkg::OP_DIGIT: begin
					if (key_word.digit <= dssw_pkg::DIGIT_MAX) begin
						for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
							digit_d[i] = digit_q[i-1];
						end
						digit_d[0] = key_word.digit;
						sp_d       = sp_shift;
					end
				end
				dssw_pkg::OP_START_STOP: begin
					active_d = 1'b0;
					digit_d  = '{default: '0};
					sp_d     = '0;
				end
				dssw_pkg::OP_TICK: begin
					if (active_q) begin
						if (tick_inc >= hp_q) begin
							level_d = ~level_q;
							tick_d  = '0;
						end else begin
							tick_d = tick_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			hp_d     = hp_calc;
			tick_d   = '0;
			level_d  = 1'b0;
			active_d = 1'b1;
		end
	end

	// Hold the architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q  <= '{default: '0};
			sp_q     <= '0;
			hp_q     <= '0;
			tick_q   <= '0;
			level_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			digit_q  <= digit_d;
			sp_q     <= sp_d;
			hp_q     <= hp_d;
			tick_q   <= tick_d;
			level_q  <= level_d;
			active_q <= active_d;
		end
	end

	// Load and advance the divider
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= DVD_W'(value_calc);
		end else if (cmd.den_load) begin
			dvd_q <= DVD_W'(dssw_pkg::HALF_NUM);
			dsr_q <= DEN_W'(den_full);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial_sub) : DEN_W'(trial);
		end
	end

	assign active                   = active_q;
	assign result.wave_level        = level_d;
	assign result.running           = active_d;
	assign result.setpoint          = dssw_pkg::SP_FIELD_W'(sp_d);
	assign result.half_period_ticks = hp_d;

`ifndef ASSERT_OFF
	a_tick_below_half: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> tick_q < hp_q)
		else $error("tick count reached half period while running");

	a_half_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hp_q <= dssw_pkg::HP_MAX)
		else $error("half period above its bound");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(!active_q && $past(active_q)) |-> sp_q == '0)
		else $error("setpoint not cleared on stop");
`endif

endmodule

/* rtl/dssw_obuf.sv */
// ----------------------------------------------------------------------------
// dssw_obuf: result buffer
// Two-entry output register with skid slot, so an item can be taken
// while an earlier result still waits downstream.
// ----------------------------------------------------------------------------
module dssw_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dssw_pkg::stat_word_t  word,
	output logic                  full,
	output logic                  stat_valid,
	input  logic                  stat_stall,
	output dssw_pkg::stat_word_t  stat_word
);

	dssw_pkg::stat_word_t out_q, skid_q;
	logic                 out_v_q, skid_v_q;
	logic                 pop;

	assign pop = out_v_q && !stat_stall;

	// Advance the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Move the result words
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= word;
				end
			end else if (push) begin
				out_q <= word;
			end
		end else if (push) begin
			skid_q <= word;
		end
	end

	assign full       = skid_v_q;
	assign stat_valid = out_v_q;
	assign stat_word  = out_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot holds a word while the output slot is empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into a full buffer");
`endif

endmodule

/* rtl/decimal_setpoint_square_wave_generator.sv */
// ----------------------------------------------------------------------------
// decimal_setpoint_square_wave_generator: keypad-set square wave source
// Top level: item controller, datapath and result buffer.
// ----------------------------------------------------------------------------
// Each key word yields one status word. Digit, tick, stop and unused-opcode
// words are applied when taken, so ticks stream at one per clock unless the
// result buffer is full. A start word occupies the block until its half
// period is committed: the value setpoint / 3 + 50 comes from a reciprocal
// multiply in the accepting cycle, the divisor value * 1000 is loaded in
// the next, then a restoring divider retires one quotient bit per cycle for
// 460829493 / (value * 1000) and the FIN state commits the half period;
// key_stall stays high meanwhile. Status words leave through a two-entry
// buffer, so one more key word is taken while a status word is stalled.
module decimal_setpoint_square_wave_generator #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_valid,
	output logic                  key_stall,
	input  dssw_pkg::key_word_t   key_word,
	output logic                  stat_valid,
	input  logic                  stat_stall,
	output dssw_pkg::stat_word_t  stat_word
);

	localparam longint SP_MAX  = dssw_pkg::pow10(DIGIT_COUNT) - 1;
	localparam int     SP_W    = $clog2(SP_MAX + 1);
	localparam int     SP1_W   = $clog2(SP_MAX + dssw_pkg::VALUE_BIAS + 1);
	localparam longint VAL_MAX = (SP_MAX + dssw_pkg::VALUE_BIAS) / dssw_pkg::VALUE_DIVISOR;
	localparam int     VAL_W   = $clog2(VAL_MAX + 1);
	localparam int     DEN_W   = $clog2(VAL_MAX * dssw_pkg::VALUE_SCALE + 1);
	localparam int     DVD_W   = (SP1_W > dssw_pkg::HALF_W) ? SP1_W : dssw_pkg::HALF_W;

	dssw_pkg::ctrl_cmd_t  cmd;
	dssw_pkg::stat_word_t result;
	logic                 active;
	logic                 obuf_full;

	dssw_ctrl #(
		.STEPS(DVD_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.opcode    (key_word.opcode),
		.active    (active),
		.obuf_full (obuf_full),
		.cmd       (cmd)
	);

	dssw_dp #(
		.DIGIT_COUNT (DIGIT_COUNT),
		.SP_W        (SP_W),
		.VAL_W       (VAL_W),
		.DEN_W       (DEN_W),
		.DVD_W       (DVD_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key_word (key_word),
		.active   (active),
		.result   (result)
	);

	dssw_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd.apply || cmd.finish),
		.word       (result),
		.full       (obuf_full),
		.stat_valid (stat_valid),
		.stat_stall (stat_stall),
		.stat_word  (stat_word)
	);

endmodule
